>>> design/ssq_pkg.sv
// ssq_pkg: shared constants, event codes and controller/datapath interface types
`default_nettype none

package ssq_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int THREAD_ID_BITS = 6;
  localparam int MAX_RESULTS    = 16;

  localparam int TIME_W  = 64;
  localparam int DUR_W   = 32;
  localparam int EVENT_W = 3;

  localparam logic [EVENT_W-1:0] EV_WOKEN    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_ACCEPTED = 3'd1;
  localparam logic [EVENT_W-1:0] EV_IGNORED  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_FULL     = 3'd3;
  localparam logic [EVENT_W-1:0] EV_IDLE     = 3'd4;

  localparam logic FUNC_SLEEP = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef struct packed {
    logic               accept;
    logic               insert;
    logic               pop;
    logic               load;
    logic [EVENT_W-1:0] code;
    logic               last;
  } ssq_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dur_zero;
    logic full;
    logic head_rel;
    logic next_rel;
  } ssq_sts_t;

endpackage

`default_nettype wire

>>> design/sorted_sleep_timer_queue_unit.sv
// sorted_sleep_timer_queue_unit: top level of the sorted sleep timer queue
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | func, thread_id, duration
//  out_    | output    | out_valid / out_stall| event_code, woken_id, wake_time, tick_count, last
//
// a sleep request: wake time is computed and registered on acceptance, then the
// sorted chain inserts it in one shift as the result beat is loaded.
// a tick yields one result beat per release (at least 1); each release
// pops the chain head, so releases run one per cycle while the output is not stalled.
// reset clears the counter, the chain valid bits and the output valid bit at once.
// a stalled output register holds the sequencer; input is taken only between items.
`default_nettype none

module sorted_sleep_timer_queue_unit
  import ssq_pkg::*;
#(
  parameter int QueueDepth   = QUEUE_DEPTH,
  parameter int ThreadIdBits = THREAD_ID_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_func,
  input  wire logic [ThreadIdBits-1:0] in_thread_id,
  input  wire logic [DUR_W-1:0]        in_duration,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [EVENT_W-1:0]           out_event_code,
  output logic [ThreadIdBits-1:0]      out_woken_id,
  output logic [TIME_W-1:0]            out_wake_time,
  output logic [TIME_W-1:0]            out_tick_count,
  output logic                         out_last
);

  ssq_cmd_t cmd;
  ssq_sts_t sts;

  ssq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssq_datapath #(
    .QueueDepth   (QueueDepth),
    .ThreadIdBits (ThreadIdBits)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_thread_id   (in_thread_id),
    .in_duration    (in_duration),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_code (out_event_code),
    .out_woken_id   (out_woken_id),
    .out_wake_time  (out_wake_time),
    .out_tick_count (out_tick_count),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

>>> design/ssq_ctrl.sv
// ssq_ctrl: controller state machine for sleep, tick and release sequencing
`default_nettype none

module ssq_ctrl
  import ssq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_func,
  output logic          in_stall,
  input  wire ssq_sts_t sts,
  output ssq_cmd_t      cmd
);

  localparam int RelW = $clog2(MAX_RESULTS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SLEEP = 2'd1;
  localparam logic [1:0] S_TICK  = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [RelW-1:0] rel_r, rel_nxt;
  logic            cap_hit;

  assign in_stall = (state_r != S_IDLE);
  assign cap_hit  = (rel_r == RelW'(MAX_RESULTS - 1));

  always_comb begin
    state_nxt  = state_r;
    rel_nxt    = rel_r;
    cmd        = '0;
    cmd.code   = EV_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          rel_nxt    = '0;
          state_nxt  = (in_func == FUNC_TICK) ? S_TICK : S_SLEEP;
        end
      end
      S_SLEEP: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          cmd.last = 1'b1;
          priority if (sts.dur_zero) begin
            cmd.code = EV_IGNORED;
          end else if (sts.full) begin
            cmd.code = EV_FULL;
          end else begin
            cmd.code   = EV_ACCEPTED;
            cmd.insert = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.head_rel) begin
            cmd.code = EV_WOKEN;
            cmd.pop  = 1'b1;
            cmd.last = !sts.next_rel || cap_hit;
            if (cmd.last) begin
              state_nxt = S_IDLE;
            end else begin
              rel_nxt = rel_r + RelW'(1);
            end
          end else begin
            cmd.code  = EV_IDLE;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rel_r   <= rel_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/ssq_datapath.sv
// ssq_datapath: tick counter, sorted shift chain of sleepers and output register
`default_nettype none

module ssq_datapath
  import ssq_pkg::*;
#(
  parameter int QueueDepth   = QUEUE_DEPTH,
  parameter int ThreadIdBits = THREAD_ID_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ssq_cmd_t                cmd,
  output ssq_sts_t                     sts,
  input  wire logic                    in_func,
  input  wire logic [ThreadIdBits-1:0] in_thread_id,
  input  wire logic [DUR_W-1:0]        in_duration,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [EVENT_W-1:0]           out_event_code,
  output logic [ThreadIdBits-1:0]      out_woken_id,
  output logic [TIME_W-1:0]            out_wake_time,
  output logic [TIME_W-1:0]            out_tick_count,
  output logic                         out_last
);

  logic [TIME_W-1:0]       count_r;
  logic [TIME_W-1:0]       req_wt_r;
  logic [ThreadIdBits-1:0] req_id_r;
  logic                    dur_zero_r;
  logic [TIME_W:0]         wt_sum;

  logic [TIME_W-1:0]       e_wt_r   [QueueDepth];
  logic [ThreadIdBits-1:0] e_id_r   [QueueDepth];
  logic [QueueDepth-1:0]   e_vld_r;
  logic [TIME_W-1:0]       e_wt_nxt [QueueDepth];
  logic [ThreadIdBits-1:0] e_id_nxt [QueueDepth];
  logic [QueueDepth-1:0]   e_vld_nxt;
  logic [QueueDepth-1:0]   le;

  logic                    out_valid_r;

  // saturating wake time
  assign wt_sum = {1'b0, count_r} + {{(TIME_W - DUR_W + 1){1'b0}}, in_duration};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.accept && in_func == FUNC_TICK) begin
      count_r <= count_r + TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_id_r   <= in_thread_id;
      dur_zero_r <= (in_duration == '0);
      req_wt_r   <= wt_sum[TIME_W] ? {TIME_W{1'b1}} : wt_sum[TIME_W-1:0];
    end
  end

  // sorted chain: valid entries form a prefix, ascending wake time
  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    assign le[g] = e_vld_r[g] && (e_wt_r[g] <= req_wt_r);

    always_comb begin
      e_wt_nxt[g]  = e_wt_r[g];
      e_id_nxt[g]  = e_id_r[g];
      e_vld_nxt[g] = e_vld_r[g];
      if (cmd.insert && !le[g]) begin
        if (g == 0) begin
          e_wt_nxt[g]  = req_wt_r;
          e_id_nxt[g]  = req_id_r;
          e_vld_nxt[g] = 1'b1;
        end else if (le[(g == 0) ? 0 : g - 1]) begin
          e_wt_nxt[g]  = req_wt_r;
          e_id_nxt[g]  = req_id_r;
          e_vld_nxt[g] = 1'b1;
        end else begin
          e_wt_nxt[g]  = e_wt_r[(g == 0) ? 0 : g - 1];
          e_id_nxt[g]  = e_id_r[(g == 0) ? 0 : g - 1];
          e_vld_nxt[g] = e_vld_r[(g == 0) ? 0 : g - 1];
        end
      end else if (cmd.pop) begin
        if (g == QueueDepth - 1) begin
          e_vld_nxt[g] = 1'b0;
        end else begin
          e_wt_nxt[g]  = e_wt_r[(g == QueueDepth - 1) ? g : g + 1];
          e_id_nxt[g]  = e_id_r[(g == QueueDepth - 1) ? g : g + 1];
          e_vld_nxt[g] = e_vld_r[(g == QueueDepth - 1) ? g : g + 1];
        end
      end
    end

    always_ff @(posedge clk) begin
      e_wt_r[g] <= e_wt_nxt[g];
      e_id_r[g] <= e_id_nxt[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= '0;
    end else begin
      e_vld_r <= e_vld_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.dur_zero = dur_zero_r;
  assign sts.full     = e_vld_r[QueueDepth-1];
  assign sts.head_rel = e_vld_r[0] && (e_wt_r[0] <= count_r);
  assign sts.next_rel = e_vld_r[1] && (e_wt_r[1] <= count_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_event_code <= cmd.code;
      out_last       <= cmd.last;
      out_tick_count <= count_r;
      unique case (cmd.code)
        EV_WOKEN: begin
          out_woken_id  <= e_id_r[0];
          out_wake_time <= e_wt_r[0];
        end
        EV_ACCEPTED, EV_FULL: begin
          out_woken_id  <= req_id_r;
          out_wake_time <= req_wt_r;
        end
        EV_IGNORED: begin
          out_woken_id  <= req_id_r;
          out_wake_time <= '0;
        end
        default: begin
          out_woken_id  <= '0;
          out_wake_time <= '0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> design/ssq_checker.sv
// ssq_checker: port-level assertions for the sorted sleep timer queue, with bind
`default_nettype none

module ssq_checker
  import ssq_pkg::*;
#(
  parameter int ThreadIdBits = THREAD_ID_BITS
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [EVENT_W-1:0]      out_event_code,
  input wire logic [ThreadIdBits-1:0] out_woken_id,
  input wire logic [TIME_W-1:0]       out_wake_time,
  input wire logic [TIME_W-1:0]       out_tick_count,
  input wire logic                    out_last
);

  // stalled beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_code)
      && $stable(out_wake_time) && $stable(out_last))
    else $error("stalled output beat changed");

  // only a release can be followed by more beats of the same item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_code != EV_WOKEN |-> out_last)
    else $error("non-release beat without last");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_code == EV_IDLE |-> out_woken_id == '0 && out_wake_time == '0)
    else $error("idle tick beat carries an entry");

  a_woken_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_code == EV_WOKEN |-> out_wake_time <= out_tick_count)
    else $error("released entry not yet expired");

endmodule

bind sorted_sleep_timer_queue_unit ssq_checker #(
  .ThreadIdBits (ThreadIdBits)
) u_ssq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_code (out_event_code),
  .out_woken_id   (out_woken_id),
  .out_wake_time  (out_wake_time),
  .out_tick_count (out_tick_count),
  .out_last       (out_last)
);

`default_nettype wire

>>> tb/tb_sorted_sleep_timer_queue_unit.sv
// testbench for the sorted sleep timer queue: directed and random sleeps and ticks
`timescale 1ns / 1ps

module tb_sorted_sleep_timer_queue_unit;
  import ssq_pkg::*;

  typedef logic [THREAD_ID_BITS-1:0] thread_t;
  typedef logic [TIME_W-1:0]         ticks_t;
  typedef logic [DUR_W-1:0]          dur_t;
  typedef logic [EVENT_W-1:0]        event_t;

  typedef struct {
    ticks_t  wake;
    thread_t thread;
  } sleeper_t;

  typedef struct {
    event_t  code;
    thread_t id;
    ticks_t  wake;
    ticks_t  tick;
    logic    last;
  } result_beat_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 160;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  logic    in_func;
  thread_t in_thread_id;
  dur_t    in_duration;
  logic    out_valid;
  logic    out_stall;
  event_t  out_event_code;
  thread_t out_woken_id;
  ticks_t  out_wake_time;
  ticks_t  out_tick_count;
  logic    out_last;

  sleeper_t     sleepers[$];
  result_beat_t due_beats[$];
  ticks_t       model_ticks;
  result_beat_t seen;
  int           mismatches;
  int           idle_cycles;
  logic         no_gaps;
  logic         hold_off_req;

  sorted_sleep_timer_queue_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_thread_id  (in_thread_id),
    .in_duration   (in_duration),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_code(out_event_code),
    .out_woken_id  (out_woken_id),
    .out_wake_time (out_wake_time),
    .out_tick_count(out_tick_count),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_beat(event_t code, thread_t id, ticks_t wake, logic last);
    result_beat_t b;
    b.code = code;
    b.id   = id;
    b.wake = wake;
    b.tick = model_ticks;
    b.last = last;
    due_beats.push_back(b);
  endfunction

  // works out the result beats of one accepted item and updates the sleeper list
  function automatic void forecast_results(logic f, thread_t tid, dur_t dur);
    logic [TIME_W:0] sum;
    ticks_t          wt;
    sleeper_t        s;
    int              pos;
    int              released;
    logic            last;
    if (f == FUNC_SLEEP) begin
      if (dur == '0) begin
        push_beat(EV_IGNORED, tid, '0, 1'b1);
      end else begin
        sum = {1'b0, model_ticks} + {{(TIME_W - DUR_W + 1){1'b0}}, dur};
        wt  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        if (sleepers.size() >= QUEUE_DEPTH) begin
          push_beat(EV_FULL, tid, wt, 1'b1);
        end else begin
          // equal wake times go behind the ones already waiting
          pos = 0;
          while (pos < sleepers.size() && sleepers[pos].wake <= wt) pos++;
          s.wake   = wt;
          s.thread = tid;
          sleepers.insert(pos, s);
          push_beat(EV_ACCEPTED, tid, wt, 1'b1);
        end
      end
    end else begin
      model_ticks = model_ticks + 1;
      released = 0;
      while (sleepers.size() != 0 && released < MAX_RESULTS &&
             sleepers[0].wake <= model_ticks) begin
        s = sleepers.pop_front();
        released++;
        last = (released == MAX_RESULTS) || (sleepers.size() == 0) ||
               (sleepers[0].wake > model_ticks);
        push_beat(EV_WOKEN, s.thread, s.wake, last);
      end
      if (released == 0) push_beat(EV_IDLE, '0, '0, 1'b1);
    end
  endfunction

  function automatic void check_field(string what, ticks_t want, ticks_t got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // valid is left high after a beat so back-to-back items need no second assignment
  task automatic send_item(input logic f, input thread_t tid, input dur_t dur);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_thread_id <= tid;
    in_duration  <= dur;
    do @(posedge clk); while (in_stall);
    forecast_results(f, tid, dur);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_tick_and_zero();
    send_item(FUNC_TICK, '0, '0);
    send_item(FUNC_SLEEP, '1, '0);
    send_item(FUNC_SLEEP, '0, '0);
    wait_all_results();
  endtask

  task automatic test_sort_order();
    send_item(FUNC_SLEEP, thread_t'(10), dur_t'(2));
    send_item(FUNC_SLEEP, thread_t'(20), dur_t'(1));
    send_item(FUNC_SLEEP, thread_t'(30), dur_t'(2));
    send_item(FUNC_TICK, '0, '0);
    send_item(FUNC_TICK, '1, '1);
    wait_all_results();
  endtask

  // sixteen entries due on the same tick, refused requests, then one tick empties all
  task automatic test_full_queue();
    int i;
    for (i = 0; i < QUEUE_DEPTH; i++)
      send_item(FUNC_SLEEP, thread_t'(63 - 4 * i), dur_t'(1));
    send_item(FUNC_SLEEP, '0, '1);
    send_item(FUNC_SLEEP, thread_t'(42), dur_t'(32'h5555_5555));
    send_item(FUNC_TICK, '0, '0);
    wait_all_results();
  endtask

  task automatic test_random_mix(input int count);
    int   n;
    int   r;
    int   tick_pct;
    dur_t dur;
    for (n = 0; n < count; n++) begin
      no_gaps  = (n >= count / 2) && (n < count / 2 + 25);
      tick_pct = (n % 60 < 30) ? 30 : 60;
      r = $urandom_range(0, 99);
      if (sleepers.size() >= QUEUE_DEPTH && r < 40) begin
        send_item(FUNC_SLEEP, thread_t'($urandom), dur_t'($urandom));
      end else if (r < 5) begin
        send_item(FUNC_SLEEP, thread_t'($urandom), '0);
      end else if (r < 100 - tick_pct) begin
        dur = ($urandom_range(0, 9) == 0) ? dur_t'($urandom_range(7, 60))
                                          : dur_t'($urandom_range(1, 6));
        send_item(FUNC_SLEEP, thread_t'($urandom), dur);
      end else begin
        send_item(FUNC_TICK, thread_t'($urandom), dur_t'($urandom));
      end
      if (n % 50 == 49) wait_all_results();
    end
    no_gaps = 1'b0;
    wait_all_results();
  endtask

  // receiver holds off while items keep coming, so the block has to stall its input
  task automatic test_output_hold_off();
    int i;
    hold_off_req = 1'b1;
    no_gaps      = 1'b1;
    for (i = 0; i < 14; i++) begin
      if (i % 3 == 2) send_item(FUNC_TICK, '0, '0);
      else send_item(FUNC_SLEEP, thread_t'($urandom), dur_t'($urandom_range(1, 3)));
    end
    no_gaps = 1'b0;
    wait_all_results();
  endtask

  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        hold = pick_gap();
        out_stall <= (hold != 0);
        repeat ((hold == 0) ? 1 : hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_beats.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got event %0d id %0d",
                 $time, out_event_code, out_woken_id);
        mismatches++;
      end else begin
        seen = due_beats.pop_front();
        check_field("event_code", ticks_t'(seen.code), ticks_t'(out_event_code));
        check_field("woken_id", ticks_t'(seen.id), ticks_t'(out_woken_id));
        check_field("wake_time", seen.wake, out_wake_time);
        check_field("tick_count", seen.tick, out_tick_count);
        check_field("last", ticks_t'(seen.last), ticks_t'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mismatches   = 0;
    idle_cycles  = 0;
    model_ticks  = '0;
    no_gaps      = 1'b0;
    hold_off_req = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_func      <= FUNC_SLEEP;
    in_thread_id <= '0;
    in_duration  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_tick_and_zero();
    test_sort_order();
    test_full_queue();
    test_random_mix(90);
    test_output_hold_off();
    test_random_mix(90);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
